// File: rtl/rbe_pkg.sv
// Shared types, constants and a helper function of the rigid body Euler step block.
package rbe_pkg;

    // Fraction bits of the time step, fixed whatever the value format.
    localparam int TS_BITS = 16;
    // Number of shift-add steps of the serial multiplier (width of the unsigned operand).
    localparam int MUL_STEPS = 31;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_INV_MASS    = 3'd0;
    localparam logic [2:0] REG_INV_INERTIA = 3'd1;
    localparam logic [2:0] REG_DAMP_X      = 3'd2;
    localparam logic [2:0] REG_DAMP_Y      = 3'd3;
    localparam logic [2:0] REG_DAMP_ANG    = 3'd4;
    localparam logic [2:0] REG_GRAV_X      = 3'd5;
    localparam logic [2:0] REG_GRAV_Y      = 3'd6;

    // Sequencer steps; every step but ST_IDLE and ST_DONE runs one arithmetic operation.
    typedef enum logic [4:0] {
        ST_IDLE, ST_IMPX, ST_IMPY, ST_IMPA, ST_AX, ST_AY, ST_AW,
        ST_VAX, ST_VAY, ST_GX, ST_GY, ST_WA,
        ST_DENX, ST_DIVX, ST_DENY, ST_DIVY, ST_DENW, ST_DIVW,
        ST_POSX, ST_POSY, ST_ANG, ST_DONE
    } rbe_state_t;

    // Start and shift control of the serial multiplier.
    typedef struct packed {
        logic start;
        logic frac_shift;
    } rbe_mul_ctl_t;

    // Saturating 32 bit signed addition.
    function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            add_sat32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            add_sat32 = s[31:0];
    endfunction

endpackage

// File: rtl/rbe_mul.sv
// Bit-serial signed by unsigned multiplier with floor shift and saturation.
module rbe_mul
    import rbe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbe_mul_ctl_t        ctl,
    input  logic signed [31:0]  a,
    input  logic [30:0]         b,
    output logic                done,
    output logic signed [31:0]  res
);

    logic signed [31:0] a_reg;
    logic signed [32:0] hi_reg;
    logic [30:0]        lo_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               frac_reg;
    logic signed [32:0] sum;
    logic signed [63:0] prod;
    logic signed [63:0] sh;

    // One partial product is added per cycle, the word shifts right by one bit.
    assign sum = hi_reg + (lo_reg[0] ? {a_reg[31], a_reg} : 33'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg    <= a;
            hi_reg   <= '0;
            lo_reg   <= b;
            frac_reg <= ctl.frac_shift;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[32], sum[32:1]};
            lo_reg <= {sum[0], lo_reg[30:1]};
        end
    end

    // Floor shift of the exact product, then clip to 32 bits.
    assign prod = {hi_reg, lo_reg};
    assign sh   = frac_reg ? (prod >>> FRAC_BITS) : (prod >>> TS_BITS);

    always_comb
    begin
        if ((&sh[63:31]) || !(|sh[63:31]))
            res = sh[31:0];
        else
            res = sh[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    assign done = done_reg;

endmodule

// File: rtl/rbe_div.sv
// Bit-serial restoring divider for the damping step, truncating toward zero.
module rbe_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num,
    input  logic [31:0]         den,
    output logic                done,
    output logic signed [31:0]  res
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] n_reg;
    logic [31:0]   q_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [31:0]   mag;
    logic [32:0]   r2;
    logic          fits;

    assign mag  = num[31] ? (~num + 32'd1) : num;
    assign r2   = {rem_reg, n_reg[NW-1]};
    assign fits = (r2 >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle from the scaled magnitude.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= {mag, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[31];
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[NW-2:0], 1'b0};
            q_reg   <= {q_reg[30:0], fits};
            rem_reg <= fits ? 32'(r2 - {1'b0, den_reg}) : r2[31:0];
        end
    end

    assign res  = neg_reg ? (~q_reg + 32'd1) : q_reg;
    assign done = done_reg;

endmodule

// File: rtl/rigid_body_euler_step_top.sv
// Top level of the rigid body Euler step: sequencer, state, registers and ports.
// Each accepted request is one tick for one 2D body and gives one result. The
// tick runs as a sequence of up to seventeen multiplications on a shared
// bit-serial multiplier and three divisions on a bit-serial divider; a static
// body runs six multiplications. A new request is taken only in the idle state,
// once the previous tick is done. The input side takes the next request while
// a result still waits in the output register.
module rigid_body_euler_step_top
    import rbe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // force_x, force_y, torque, impulse_x, impulse_y, angular_impulse, time_step
    input  logic [207:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // position_x, position_y, body_angle, velocity_x, velocity_y, spin_rate
    output logic [191:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    rbe_state_t state_reg, state_next;
    logic go_reg, go_next;

    logic [30:0] inv_mass_reg, inv_inertia_reg, damp_x_reg, damp_y_reg, damp_ang_reg;
    logic signed [31:0] grav_x_reg, grav_y_reg;

    logic signed [31:0] fx_reg, fy_reg, tq_reg, ix_reg, iy_reg, ia_reg;
    logic [15:0] dt_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg, angle_reg, vel_x_reg, vel_y_reg, spin_reg;
    logic signed [31:0] pos_x_next, pos_y_next, angle_next, vel_x_next, vel_y_next, spin_next;
    logic signed [31:0] ax_reg, ay_reg, aw_reg, ax_next, ay_next, aw_next;
    logic [31:0] den_reg, den_next;

    logic [191:0] out_reg;
    logic out_valid_reg;
    logic out_load;

    rbe_mul_ctl_t mul_ctl;
    logic signed [31:0] mul_a, mul_res;
    logic [30:0] mul_b;
    logic mul_frac, mul_done, is_div;
    logic signed [31:0] div_num, div_res;
    logic div_done;
    logic s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg    <= '0;
            inv_inertia_reg <= '0;
            damp_x_reg      <= '0;
            damp_y_reg      <= '0;
            damp_ang_reg    <= '0;
            grav_x_reg      <= '0;
            grav_y_reg      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_INV_MASS:    inv_mass_reg    <= pwdata[30:0];
                REG_INV_INERTIA: inv_inertia_reg <= pwdata[30:0];
                REG_DAMP_X:      damp_x_reg      <= pwdata[30:0];
                REG_DAMP_Y:      damp_y_reg      <= pwdata[30:0];
                REG_DAMP_ANG:    damp_ang_reg    <= pwdata[30:0];
                REG_GRAV_X:      grav_x_reg      <= pwdata;
                REG_GRAV_Y:      grav_y_reg      <= pwdata;
                default:         ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_INV_MASS:    prdata = {1'b0, inv_mass_reg};
            REG_INV_INERTIA: prdata = {1'b0, inv_inertia_reg};
            REG_DAMP_X:      prdata = {1'b0, damp_x_reg};
            REG_DAMP_Y:      prdata = {1'b0, damp_y_reg};
            REG_DAMP_ANG:    prdata = {1'b0, damp_ang_reg};
            REG_GRAV_X:      prdata = grav_x_reg;
            REG_GRAV_Y:      prdata = grav_y_reg;
            default:         prdata = '0;
        endcase
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            fx_reg <= s_tdata[31:0];
            fy_reg <= s_tdata[63:32];
            tq_reg <= s_tdata[95:64];
            ix_reg <= s_tdata[127:96];
            iy_reg <= s_tdata[159:128];
            ia_reg <= s_tdata[191:160];
            dt_reg <= s_tdata[207:192];
        end
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        aw_reg  <= aw_next;
        den_reg <= den_next;
        if (out_load)
            out_reg <= {spin_next, vel_y_next, vel_x_next, angle_next, pos_y_next, pos_x_next};
    end

    // Sequencer state and body state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            angle_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            spin_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            angle_reg <= angle_next;
            vel_x_reg <= vel_x_next;
            vel_y_reg <= vel_y_next;
            spin_reg  <= spin_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Operand selection and write-back for each step.
    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_frac   = 1'b0;
        is_div     = 1'b0;
        div_num    = vel_x_reg;
        out_load   = 1'b0;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        angle_next = angle_reg;
        vel_x_next = vel_x_reg;
        vel_y_next = vel_y_reg;
        spin_next  = spin_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        aw_next    = aw_reg;
        den_next   = den_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_IMPX;
                    go_next    = 1'b1;
                end
            end
            ST_IMPX:
            begin
                mul_a = ix_reg; mul_b = inv_mass_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    vel_x_next = add_sat32(vel_x_reg, mul_res);
                    state_next = ST_IMPY; go_next = 1'b1;
                end
            end
            ST_IMPY:
            begin
                mul_a = iy_reg; mul_b = inv_mass_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    vel_y_next = add_sat32(vel_y_reg, mul_res);
                    state_next = ST_IMPA; go_next = 1'b1;
                end
            end
            ST_IMPA:
            begin
                mul_a = ia_reg; mul_b = inv_inertia_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    spin_next  = add_sat32(spin_reg, mul_res);
                    // A static body skips straight to the position update.
                    state_next = (inv_mass_reg != '0) ? ST_AX : ST_POSX;
                    go_next    = 1'b1;
                end
            end
            ST_AX:
            begin
                mul_a = fx_reg; mul_b = inv_mass_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    ax_next = mul_res; state_next = ST_AY; go_next = 1'b1;
                end
            end
            ST_AY:
            begin
                mul_a = fy_reg; mul_b = inv_mass_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    ay_next = mul_res; state_next = ST_AW; go_next = 1'b1;
                end
            end
            ST_AW:
            begin
                mul_a = tq_reg; mul_b = inv_inertia_reg; mul_frac = 1'b1;
                if (mul_done)
                begin
                    aw_next = mul_res; state_next = ST_VAX; go_next = 1'b1;
                end
            end
            ST_VAX:
            begin
                mul_a = ax_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    vel_x_next = add_sat32(vel_x_reg, mul_res);
                    state_next = ST_VAY; go_next = 1'b1;
                end
            end
            ST_VAY:
            begin
                mul_a = ay_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    vel_y_next = add_sat32(vel_y_reg, mul_res);
                    state_next = ST_GX; go_next = 1'b1;
                end
            end
            ST_GX:
            begin
                mul_a = grav_x_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    vel_x_next = add_sat32(vel_x_reg, mul_res);
                    state_next = ST_GY; go_next = 1'b1;
                end
            end
            ST_GY:
            begin
                mul_a = grav_y_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    vel_y_next = add_sat32(vel_y_reg, mul_res);
                    state_next = ST_WA; go_next = 1'b1;
                end
            end
            ST_WA:
            begin
                mul_a = aw_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    spin_next  = add_sat32(spin_reg, mul_res);
                    state_next = ST_DENX; go_next = 1'b1;
                end
            end
            ST_DENX:
            begin
                mul_a = {1'b0, damp_x_reg}; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    den_next   = 32'(mul_res) + (32'd1 << FRAC_BITS);
                    state_next = ST_DIVX; go_next = 1'b1;
                end
            end
            ST_DIVX:
            begin
                is_div = 1'b1; div_num = vel_x_reg;
                if (div_done)
                begin
                    vel_x_next = div_res; state_next = ST_DENY; go_next = 1'b1;
                end
            end
            ST_DENY:
            begin
                mul_a = {1'b0, damp_y_reg}; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    den_next   = 32'(mul_res) + (32'd1 << FRAC_BITS);
                    state_next = ST_DIVY; go_next = 1'b1;
                end
            end
            ST_DIVY:
            begin
                is_div = 1'b1; div_num = vel_y_reg;
                if (div_done)
                begin
                    vel_y_next = div_res; state_next = ST_DENW; go_next = 1'b1;
                end
            end
            ST_DENW:
            begin
                mul_a = {1'b0, damp_ang_reg}; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    den_next   = 32'(mul_res) + (32'd1 << FRAC_BITS);
                    state_next = ST_DIVW; go_next = 1'b1;
                end
            end
            ST_DIVW:
            begin
                is_div = 1'b1; div_num = spin_reg;
                if (div_done)
                begin
                    spin_next = div_res; state_next = ST_POSX; go_next = 1'b1;
                end
            end
            ST_POSX:
            begin
                mul_a = vel_x_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    pos_x_next = add_sat32(pos_x_reg, mul_res);
                    state_next = ST_POSY; go_next = 1'b1;
                end
            end
            ST_POSY:
            begin
                mul_a = vel_y_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    pos_y_next = add_sat32(pos_y_reg, mul_res);
                    state_next = ST_ANG; go_next = 1'b1;
                end
            end
            ST_ANG:
            begin
                mul_a = spin_reg; mul_b = {15'd0, dt_reg};
                if (mul_done)
                begin
                    angle_next = add_sat32(angle_reg, mul_res);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand over to the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mul_ctl.start      = go_reg && !is_div;
    assign mul_ctl.frac_shift = mul_frac;

    rbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    rbe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg && is_div),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .res   (div_res)
    );

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/rbe_checker.sv
// Port-level checker of the rigid body Euler step and its bind statement.
module rbe_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [191:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // A tick runs through the sequencer steps, so no request is taken right after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a tick is in progress");

    // An offered result carries fully known data.
    a_known_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown(m_tdata))
        else $error("result offered with unknown data");

endmodule

bind rigid_body_euler_step_top rbe_checker u_rbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: test/tb_rigid_body_euler_step_top.sv
// Self-checking testbench of the rigid body Euler step block.
`timescale 1ns / 100ps

module tb_rigid_body_euler_step_top;
    import rbe_pkg::*;

    localparam int FRAC = 16;

    typedef struct {
        logic signed [31:0] force_x, force_y, torque, impulse_x, impulse_y, angular_impulse;
        logic [15:0]        time_step;
    } tick_t;

    typedef struct {
        logic signed [31:0] pos_x, pos_y, angle, vel_x, vel_y, spin;
    } body_t;

    // Predicts the body state after each tick and checks the results in order.
    class body_scoreboard;
        logic [30:0]        inv_mass, inv_inertia, damp_x, damp_y, damp_w;
        logic signed [31:0] grav_x, grav_y;
        body_t              body;
        body_t              pending[$];
        int                 errors;

        function new();
            inv_mass = 0; inv_inertia = 0; damp_x = 0; damp_y = 0; damp_w = 0;
            grav_x = 0; grav_y = 0;
            body = '{default: 0};
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_INV_MASS:    inv_mass = val[30:0];
                REG_INV_INERTIA: inv_inertia = val[30:0];
                REG_DAMP_X:      damp_x = val[30:0];
                REG_DAMP_Y:      damp_y = val[30:0];
                REG_DAMP_ANG:    damp_w = val[30:0];
                REG_GRAV_X:      grav_x = val;
                REG_GRAV_Y:      grav_y = val;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // Arithmetic shift of a 64 bit product floors toward minus infinity.
        function logic signed [31:0] scale(logic signed [31:0] a, longint b, int sh);
            longint p;
            p = longint'(a) * b;
            return clamp(p >>> sh);
        endfunction

        function logic signed [31:0] sum(logic signed [31:0] a, logic signed [31:0] b);
            return clamp(longint'(a) + longint'(b));
        endfunction

        function logic signed [31:0] damped(logic signed [31:0] v, logic [30:0] c,
                                            logic [15:0] dt);
            longint den;
            longint q;
            den = ((longint'(c) * longint'(dt)) >>> 16) + (64'sd1 <<< FRAC);
            q = (longint'(v) <<< FRAC) / den;
            return q[31:0];
        endfunction

        function void note_tick(tick_t t);
            logic signed [31:0] ax, ay, aw;
            longint dt;
            dt = longint'(t.time_step);
            body.vel_x = sum(body.vel_x, scale(t.impulse_x, inv_mass, FRAC));
            body.vel_y = sum(body.vel_y, scale(t.impulse_y, inv_mass, FRAC));
            body.spin = sum(body.spin, scale(t.angular_impulse, inv_inertia, FRAC));
            if (inv_mass != 0)
            begin
                ax = scale(t.force_x, inv_mass, FRAC);
                ay = scale(t.force_y, inv_mass, FRAC);
                aw = scale(t.torque, inv_inertia, FRAC);
                body.vel_x = sum(body.vel_x, scale(ax, dt, 16));
                body.vel_y = sum(body.vel_y, scale(ay, dt, 16));
                body.vel_x = sum(body.vel_x, scale(grav_x, dt, 16));
                body.vel_y = sum(body.vel_y, scale(grav_y, dt, 16));
                body.spin = sum(body.spin, scale(aw, dt, 16));
                body.vel_x = damped(body.vel_x, damp_x, t.time_step);
                body.vel_y = damped(body.vel_y, damp_y, t.time_step);
                body.spin = damped(body.spin, damp_w, t.time_step);
            end
            body.pos_x = sum(body.pos_x, scale(body.vel_x, dt, 16));
            body.pos_y = sum(body.pos_y, scale(body.vel_y, dt, 16));
            body.angle = sum(body.angle, scale(body.spin, dt, 16));
            pending.push_back(body);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endfunction

        function void check_result(logic [191:0] d);
            body_t w;
            if (pending.size() == 0)
            begin
                $display("unexpected result %h at %0t", d, $realtime);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (d[31:0] !== w.pos_x) report("position_x", d[31:0], w.pos_x);
            if (d[63:32] !== w.pos_y) report("position_y", d[63:32], w.pos_y);
            if (d[95:64] !== w.angle) report("body_angle", d[95:64], w.angle);
            if (d[127:96] !== w.vel_x) report("velocity_x", d[127:96], w.vel_x);
            if (d[159:128] !== w.vel_y) report("velocity_y", d[159:128], w.vel_y);
            if (d[191:160] !== w.spin) report("spin_rate", d[191:160], w.spin);
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    // force_x, force_y, torque, impulse_x, impulse_y, angular_impulse, time_step
    logic [207:0] s_tdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    // position_x, position_y, body_angle, velocity_x, velocity_y, spin_rate
    logic [191:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int send_idle = 24;
    int recv_idle = 82;
    bit hold_recv = 0;

    body_scoreboard sb = new();

    rigid_body_euler_step_top #(.FRAC_BITS(FRAC)) dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Receiver: random back pressure, or a long hold when asked.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    // Offers one request, holding it until it is taken.
    task automatic send_tick(tick_t t);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {t.time_step, t.angular_impulse, t.impulse_y, t.impulse_x,
                    t.torque, t.force_y, t.force_x};
        do @(posedge clk); while (!s_tready);
        sb.note_tick(t);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(65535)) - 32768;
            3: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.force_x = rand_val(); t.force_y = rand_val(); t.torque = rand_val();
        t.impulse_x = rand_val(); t.impulse_y = rand_val();
        t.angular_impulse = rand_val();
        case ($urandom_range(4))
            0: t.time_step = 16'h0000;
            1: t.time_step = 16'hFFFF;
            default: t.time_step = 16'($urandom);
        endcase
        return t;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0002_0000);
            default: return 32'({1'b0, $urandom} >> $urandom_range(31));
        endcase
    endfunction

    // Lets every outstanding request drain before touching registers.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(bit extreme);
        int i;
        for (i = 0; i < 7; i++)
        begin
            if (extreme)
                write_reg(i[2:0], (i >= 5) ? ($urandom_range(1) ? 32'h8000_0000
                                                                : 32'h7FFF_FFFF)
                                           : 32'h7FFF_FFFF);
            else if (i >= 5)
                write_reg(i[2:0], rand_val());
            else
                write_reg(i[2:0], rand_coef());
        end
    endtask

    initial
    begin
        #100ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        tick_t t;
        int    phase;
        int    n;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: static body at reset, then unit and extreme settings.
        t = '{force_x: 32'sh0001_0000, force_y: -32'sh0001_0000, torque: 32'sh0000_8000,
              impulse_x: 32'sh0002_0000, impulse_y: 32'sh7FFF_FFFF,
              angular_impulse: 32'sh8000_0000, time_step: 16'h1000};
        send_tick(t);
        drain();
        write_reg(REG_INV_INERTIA, 32'h0001_0000);
        send_tick(t);
        t.time_step = 16'h0000;
        send_tick(t);
        drain();
        write_reg(REG_INV_MASS, 32'h0001_0000);
        write_reg(REG_GRAV_Y, 32'hFFF6_0000);
        write_reg(REG_DAMP_X, 32'h0000_8000);
        for (n = 0; n < 10; n++)
            send_tick(rand_tick());
        t.time_step = 16'hFFFF;
        send_tick(t);
        t.time_step = 16'h0000;
        send_tick(t);
        drain();
        configure(1);
        for (n = 0; n < 10; n++)
            send_tick(rand_tick());
        drain();

        // Random phases with changing settings and idling patterns.
        for (phase = 0; phase < 33; phase++)
        begin
            if (phase == 11)
            begin
                send_idle = 82; recv_idle = 24;
            end
            if (phase == 22)
            begin
                send_idle = 0; recv_idle = 0;
            end
            if (phase % 4 == 0)
                configure(phase % 8 == 0 && phase != 0);
            else if (phase % 4 == 2)
                write_reg(REG_INV_MASS, 32'h0);
            else
                configure(0);
            if (phase == 25)
                hold_recv = 1;
            fork
                begin
                    if (phase == 25)
                    begin
                        repeat (4000) @(posedge clk);
                        hold_recv = 0;
                    end
                end
                begin
                    for (n = 0; n < 50; n++)
                        send_tick(rand_tick());
                end
            join
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
